// ----- rtl/lfu_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared constants and beat types for the LFU cache table: table geometry,
// request and response payloads, and the controller/datapath handshake.
// ----------------------------------------------------------------------------
package lfu_pkg;

   // table geometry
   localparam int ENTRIES     = 16;
   localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OCC_W       = $clog2(ENTRIES + 1);
   localparam int COUNT_WIDTH = 16;
   localparam int STAMP_W     = 32;
   localparam int WORD_W      = 32;
   localparam int CAP_W       = 5;

   // capacity after reset
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   // operation codes
   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   // request beat
   typedef struct packed {
      logic                     op;
      logic signed [WORD_W-1:0] lookup_key;
      logic signed [WORD_W-1:0] store_value;
   } req_type;

   // response beat
   typedef struct packed {
      logic                     hit;
      logic signed [WORD_W-1:0] read_value;
      logic                     evicted;
      logic signed [WORD_W-1:0] evicted_key;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;     // capture request, restart scan
      logic scan;     // examine one entry
      logic commit;   // apply update, load response register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_last;
   } status_type;

endpackage : lfu_pkg
`default_nettype wire

// ----- rtl/lfu_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_ctrl
// Sequencer for one access: capture, scan every entry once, commit the
// update and hand the response beat to the output register.
// ----------------------------------------------------------------------------
module lfu_ctrl
   import lfu_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   // response register can take a beat when empty or draining this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // commands
   always_comb begin
      cmd        = '0;
      cmd.load   = (state_ff == ST_IDLE) && req_valid;
      cmd.scan   = (state_ff == ST_SCAN);
      cmd.commit = (state_ff == ST_COMMIT) && out_free;
   end

   // state and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (status.scan_last) begin
                  state_ff <= ST_COMMIT;
               end
            end
            ST_COMMIT: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule : lfu_ctrl
`default_nettype wire

// ----- rtl/lfu_dpath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_dpath
// Entry storage, scan trackers (key match, first free slot, LFU victim with
// oldest-stamp tiebreak), occupancy, stamp counter, capacity register and
// the response register.
// ----------------------------------------------------------------------------
module lfu_dpath
   import lfu_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cmd_type          cmd,
   output status_type            status,
   input  wire req_type          req_data,
   output rsp_type               rsp_data,
   input  wire logic             csr_write,
   input  wire logic [CAP_W-1:0] csr_data
);

   // entry storage; only valid bits are reset
   logic [ENTRIES-1:0]     valid_ff;
   logic [WORD_W-1:0]      key_ff   [ENTRIES];
   logic [WORD_W-1:0]      data_ff  [ENTRIES];
   logic [COUNT_WIDTH-1:0] count_ff [ENTRIES];
   logic [STAMP_W-1:0]     stamp_ff [ENTRIES];

   logic [OCC_W-1:0]   occ_ff,   occ_in;
   logic [STAMP_W-1:0] clock_ff, clock_in;
   logic [CAP_W-1:0]   cap_ff;
   req_type            req_ff;
   rsp_type            rsp_ff,   rsp_in;
   logic [IDX_W-1:0]   scan_idx_ff;

   // scan trackers
   logic                   match_found_ff;
   logic [IDX_W-1:0]       match_idx_ff;
   logic [WORD_W-1:0]      match_data_ff;
   logic [COUNT_WIDTH-1:0] match_count_ff;
   logic                   free_found_ff;
   logic [IDX_W-1:0]       free_idx_ff;
   logic                   best_found_ff;
   logic [IDX_W-1:0]       best_idx_ff;
   logic [WORD_W-1:0]      best_key_ff;
   logic [COUNT_WIDTH-1:0] best_count_ff;
   logic [STAMP_W-1:0]     best_stamp_ff;

   // entry under scan
   logic                   cur_valid;
   logic [WORD_W-1:0]      cur_key;
   logic [COUNT_WIDTH-1:0] cur_count;
   logic [STAMP_W-1:0]     cur_stamp;
   logic                   cur_better;

   // commit write controls
   logic                   wr_key_en, wr_data_en, wr_meta_en;
   logic [IDX_W-1:0]       wr_idx_in;
   logic [WORD_W-1:0]      wr_data_in;
   logic [COUNT_WIDTH-1:0] wr_count_in;
   logic                   clr_en, set_en;
   logic [OCC_W-1:0]       cap_eff;
   logic                   need_evict, do_evict;
   logic [OCC_W-1:0]       occ_tmp;

   assign status.scan_last = cmd.scan && (scan_idx_ff == IDX_W'(ENTRIES - 1));
   assign rsp_data         = rsp_ff;

   assign cur_valid = valid_ff[scan_idx_ff];
   assign cur_key   = key_ff[scan_idx_ff];
   assign cur_count = count_ff[scan_idx_ff];
   assign cur_stamp = stamp_ff[scan_idx_ff];
   assign cur_better = !best_found_ff || (cur_count < best_count_ff) ||
                       ((cur_count == best_count_ff) && (cur_stamp < best_stamp_ff));

   // capacity above the table size acts as the table size
   assign cap_eff = (cap_ff > CAP_W'(ENTRIES)) ? OCC_W'(ENTRIES) : OCC_W'(cap_ff);

   // commit decision
   always_comb begin
      rsp_in      = '0;
      wr_key_en   = 1'b0;
      wr_data_en  = 1'b0;
      wr_meta_en  = 1'b0;
      wr_idx_in   = match_idx_ff;
      wr_data_in  = req_ff.store_value;
      wr_count_in = (&match_count_ff) ? match_count_ff
                                      : COUNT_WIDTH'(match_count_ff + 1'b1);
      clr_en      = 1'b0;
      set_en      = 1'b0;
      need_evict  = (occ_ff >= cap_eff) || !free_found_ff;
      do_evict    = 1'b0;
      if (req_ff.op == OP_GET) begin
         if (match_found_ff) begin
            rsp_in.hit        = 1'b1;
            rsp_in.read_value = match_data_ff;
            wr_meta_en        = 1'b1;
         end else begin
            rsp_in.read_value = '1;
         end
      end else if (cap_eff != '0) begin
         if (match_found_ff) begin
            rsp_in.hit = 1'b1;
            wr_data_en = 1'b1;
            wr_meta_en = 1'b1;
         end else begin
            do_evict           = need_evict && best_found_ff;
            clr_en             = do_evict;
            rsp_in.evicted     = do_evict;
            rsp_in.evicted_key = do_evict ? best_key_ff : '0;
            // first free slot once the victim is gone
            if (free_found_ff && !(do_evict && (best_idx_ff < free_idx_ff))) begin
               wr_idx_in = free_idx_ff;
               set_en    = 1'b1;
            end else if (do_evict) begin
               wr_idx_in = best_idx_ff;
               set_en    = 1'b1;
            end
            wr_key_en   = set_en;
            wr_data_en  = set_en;
            wr_meta_en  = set_en;
            wr_count_in = COUNT_WIDTH'(1);
         end
      end
   end

   // occupancy and stamp counter updates
   always_comb begin
      occ_tmp = (do_evict && (occ_ff != '0)) ? OCC_W'(occ_ff - 1'b1) : occ_ff;
      occ_in  = (set_en && (occ_tmp < OCC_W'(ENTRIES))) ? OCC_W'(occ_tmp + 1'b1) : occ_tmp;
      clock_in = (wr_meta_en && !(&clock_ff)) ? STAMP_W'(clock_ff + 1'b1) : clock_ff;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
         clock_ff <= '0;
         cap_ff   <= CAP_RESET;
      end else begin
         if (csr_write) begin
            cap_ff <= csr_data;
         end
         if (cmd.commit) begin
            occ_ff   <= occ_in;
            clock_ff <= clock_in;
            if (clr_en) begin
               valid_ff[best_idx_ff] <= 1'b0;
            end
            if (set_en) begin
               valid_ff[wr_idx_in] <= 1'b1;
            end
         end
      end
   end

   // entry payload writes
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (wr_key_en) begin
            key_ff[wr_idx_in] <= req_ff.lookup_key;
         end
         if (wr_data_en) begin
            data_ff[wr_idx_in] <= wr_data_in;
         end
         if (wr_meta_en) begin
            count_ff[wr_idx_in] <= wr_count_in;
            stamp_ff[wr_idx_in] <= clock_ff;
         end
      end
   end

   // request capture, scan trackers, response register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff         <= req_data;
         scan_idx_ff    <= '0;
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
         best_found_ff  <= 1'b0;
      end else if (cmd.scan) begin
         scan_idx_ff <= IDX_W'(scan_idx_ff + 1'b1);
         if (cur_valid && (cur_key == req_ff.lookup_key) && !match_found_ff) begin
            match_found_ff <= 1'b1;
            match_idx_ff   <= scan_idx_ff;
            match_data_ff  <= data_ff[scan_idx_ff];
            match_count_ff <= cur_count;
         end
         if (!cur_valid && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= scan_idx_ff;
         end
         if (cur_valid && cur_better) begin
            best_found_ff <= 1'b1;
            best_idx_ff   <= scan_idx_ff;
            best_key_ff   <= cur_key;
            best_count_ff <= cur_count;
            best_stamp_ff <= cur_stamp;
         end
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule : lfu_dpath
`default_nettype wire

// ----- rtl/lfu_cache_table.sv -----
`default_nettype none
// Flow: request capture, a scan of all 16 entries one at a time, the commit,
//   then the response register; the commit waits while that register holds an undrained beat.
// One access at a time: a new request is taken only back in the idle state.
// Reset: synchronous; clears all valid bits, occupancy and the stamp counter,
//   sets capacity to 16. No clearing pass; the block is ready at once.
// ----------------------------------------------------------------------------
// lfu_cache_table
// Key-value table with least-frequently-used replacement and an oldest-stamp
// tiebreak; gets, puts and eviction reporting over valid/ready channels.
// ----------------------------------------------------------------------------
module lfu_cache_table
   import lfu_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire req_type          req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_type               rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [CAP_W-1:0] csr_data
);

   cmd_type    cmd;
   status_type status;

   // capacity register always takes a write
   assign csr_ready = 1'b1;

   lfu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lfu_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data)
   );

`ifndef SYNTHESIS
   // at most one command per cycle
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.scan, cmd.commit}))
      else $error("controller issued overlapping commands");

   // a commit always presents a response beat next cycle
   a_commit_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("commit without response beat");

   // an eviction only comes from a put that missed
   a_evict_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.evicted) |-> (!rsp_data.hit && (rsp_data.read_value == '0)))
      else $error("eviction reported on a hit or a get");

   // no victim key without an eviction
   a_evkey_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.evicted) |-> (rsp_data.evicted_key == '0))
      else $error("evicted key set without eviction");
`endif

endmodule : lfu_cache_table
`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lfu_cache_table. A directed table walks the key
// and value extremes, get and put, ignored puts at zero capacity, capacity
// above the table size and capacity lowered below the fill level. Random
// phases then mix gets and puts over a small key pool under several
// capacities and idle patterns. Every response is checked: against the
// expected beat a row gives, else a behavioral table model in the bench.
// ----------------------------------------------------------------------------
module tb;
   import lfu_pkg::*;

   localparam int LATENCY     = 18;
   localparam int QUIET_LIMIT = 4000;
   localparam int HOLD_CYCLES = 300;
   localparam int KEY_POOL    = 32;

   typedef enum logic {ROW_ACCESS, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic         op;
      logic [31:0]  key;
      logic [31:0]  value;   // capacity for csr rows
      logic         typed;   // expected response given in the row
      rsp_type      want;
   } plan_row_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   rsp_type          rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [CAP_W-1:0] csr_data;

   lfu_cache_table i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // table model
   logic                   tab_valid [ENTRIES];
   logic [WORD_W-1:0]      tab_key   [ENTRIES];
   logic [WORD_W-1:0]      tab_data  [ENTRIES];
   logic [COUNT_WIDTH-1:0] tab_uses  [ENTRIES];
   logic [STAMP_W-1:0]     tab_stamp [ENTRIES];
   int                     tab_fill;
   logic [STAMP_W-1:0]     stamp_now;
   logic [CAP_W-1:0]       cap_setting;

   rsp_type pending_rsp [$];
   int      mismatch_count;
   int      quiet_cycles;

   // sender side of the row being offered
   logic    use_typed;
   rsp_type typed_rsp;

   // idle controls
   int source_idle_pct;
   int sink_stall_pct;
   int hold_request;
   int hold_left;

   logic [31:0] key_pool [KEY_POOL];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- model
   function automatic int lookup_entry(logic [WORD_W-1:0] key);
      for (int i = 0; i < ENTRIES; i++)
         if (tab_valid[i] && tab_key[i] == key) return i;
      return -1;
   endfunction

   function automatic int first_free();
      for (int i = 0; i < ENTRIES; i++)
         if (!tab_valid[i]) return i;
      return -1;
   endfunction

   // lowest count, then oldest stamp, then lowest index
   function automatic int choose_victim();
      int best;
      best = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (!tab_valid[i]) continue;
         if (best < 0 || tab_uses[i] < tab_uses[best] ||
             (tab_uses[i] == tab_uses[best] && tab_stamp[i] < tab_stamp[best]))
            best = i;
      end
      return best;
   endfunction

   // stamp and count both saturate; neither limit is reachable in this run
   function automatic logic [STAMP_W-1:0] take_stamp();
      logic [STAMP_W-1:0] s;
      s = stamp_now;
      if (stamp_now != '1) stamp_now = stamp_now + 1'b1;
      return s;
   endfunction

   function automatic void bump_use(int i);
      if (tab_uses[i] != '1) tab_uses[i] = tab_uses[i] + 1'b1;
      tab_stamp[i] = take_stamp();
   endfunction

   function automatic void clear_table();
      for (int i = 0; i < ENTRIES; i++) begin
         tab_valid[i] = 1'b0;
         tab_key[i]   = '0;
         tab_data[i]  = '0;
         tab_uses[i]  = '0;
         tab_stamp[i] = '0;
      end
      tab_fill    = 0;
      stamp_now   = '0;
      cap_setting = CAP_RESET;
   endfunction

   function automatic rsp_type apply_access(req_type r);
      rsp_type o;
      int      eff_cap;
      int      slot;
      int      victim;
      o       = '0;
      eff_cap = (cap_setting > ENTRIES) ? ENTRIES : int'(cap_setting);
      slot    = lookup_entry(r.lookup_key);
      if (r.op == OP_GET) begin
         if (slot >= 0) begin
            o.hit        = 1'b1;
            o.read_value = tab_data[slot];
            bump_use(slot);
         end else begin
            o.read_value = '1;
         end
      end else if (eff_cap != 0) begin
         if (slot >= 0) begin
            o.hit          = 1'b1;
            tab_data[slot] = r.store_value;
            bump_use(slot);
         end else begin
            // full (or over a lowered limit): drop exactly one entry
            if (tab_fill >= eff_cap || first_free() < 0) begin
               victim = choose_victim();
               if (victim >= 0) begin
                  o.evicted         = 1'b1;
                  o.evicted_key     = tab_key[victim];
                  tab_valid[victim] = 1'b0;
                  if (tab_fill > 0) tab_fill--;
               end
            end
            slot = first_free();
            if (slot >= 0) begin
               tab_valid[slot] = 1'b1;
               tab_key[slot]   = r.lookup_key;
               tab_data[slot]  = r.store_value;
               tab_uses[slot]  = COUNT_WIDTH'(1);
               tab_stamp[slot] = take_stamp();
               if (tab_fill < ENTRIES) tab_fill++;
            end
         end
      end
      return o;
   endfunction

   // ------------------------------------------------------------ checking
   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (mismatch_count < 100)
         $display("%0t mismatch %s: got %h, expected %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // one place for every accepted beat: checks, predictions, register writes
   always @(posedge clock) begin
      rsp_type want;
      logic    moved;
      if (reset) begin
         clear_table();
         pending_rsp.delete();
         quiet_cycles = 0;
      end else begin
         moved = 1'b0;
         if (rsp_valid && rsp_ready) begin
            moved = 1'b1;
            if (pending_rsp.size() == 0) begin
               report_mismatch("unexpected response", rsp_data.read_value, '0);
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_data.hit !== want.hit)
                  report_mismatch("hit", 32'(rsp_data.hit), 32'(want.hit));
               if (rsp_data.read_value !== want.read_value)
                  report_mismatch("read_value", rsp_data.read_value, want.read_value);
               if (rsp_data.evicted !== want.evicted)
                  report_mismatch("evicted", 32'(rsp_data.evicted), 32'(want.evicted));
               if (rsp_data.evicted_key !== want.evicted_key)
                  report_mismatch("evicted_key", rsp_data.evicted_key, want.evicted_key);
            end
         end
         if (csr_valid && csr_ready) begin
            moved       = 1'b1;
            cap_setting = csr_data;
         end
         if (req_valid && req_ready) begin
            moved = 1'b1;
            want  = apply_access(req_data);
            pending_rsp.push_back(use_typed ? typed_rsp : want);
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t watchdog: no beat for %0d cycles", $realtime, QUIET_LIMIT);
            $display("tb failed");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------ receiver
   initial begin
      rsp_ready = 1'b0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= sink_stall_pct);
         end
      end
   end

   // -------------------------------------------------------------- sender
   // all sender tasks start and end at a falling edge
   task automatic send_access(input logic op, input logic [31:0] key,
                              input logic [31:0] val, input logic typed,
                              input rsp_type want);
      req_type r;
      r.op          = op;
      r.lookup_key  = key;
      r.store_value = val;
      if (source_idle_pct != 0 && $urandom_range(99) < source_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < source_idle_pct);
      end
      use_typed = typed;
      typed_rsp = want;
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_rsp.size() != 0);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      wait_drained();
      csr_data  <= cap;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic rsp_type rsp_of(logic hit, logic [31:0] rd, logic ev, logic [31:0] evk);
      rsp_type o;
      o.hit         = hit;
      o.read_value  = rd;
      o.evicted     = ev;
      o.evicted_key = evk;
      return o;
   endfunction

   function automatic plan_row_type access_row(logic op, logic [31:0] key, logic [31:0] val);
      return '{ROW_ACCESS, op, key, val, 1'b0, rsp_type'('0)};
   endfunction

   function automatic plan_row_type typed_row(logic op, logic [31:0] key, logic [31:0] val,
                                              logic hit, logic [31:0] rd);
      return '{ROW_ACCESS, op, key, val, 1'b1, rsp_of(hit, rd, 1'b0, '0)};
   endfunction

   function automatic plan_row_type capacity_row(logic [CAP_W-1:0] cap);
      return '{ROW_CSR, OP_GET, 32'h0, 32'(cap), 1'b0, rsp_type'('0)};
   endfunction

   // ---------------------------------------------------------------- main
   initial begin
      plan_row_type     plan [$];
      int               phase_cap   [9];
      int               phase_items [9];
      logic [CAP_W-1:0] cap;
      int               eff_cap;
      int               span;
      logic             op;
      logic [31:0]      key;

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_data        = '0;
      csr_valid       = 1'b0;
      csr_data        = '0;
      use_typed       = 1'b0;
      typed_rsp       = '0;
      source_idle_pct = 0;
      sink_stall_pct  = 0;
      hold_request    = 0;
      mismatch_count  = 0;
      clear_table();

      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: extremes of key and value, both operations, zero capacity,
      // capacity above the table size and lowered below the fill level
      plan.push_back(typed_row(OP_GET, 32'h0000_0000, 32'h0,           1'b0, 32'hFFFF_FFFF));
      plan.push_back(typed_row(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF,   1'b0, 32'h0));
      plan.push_back(typed_row(OP_GET, 32'h8000_0000, 32'hFFFF_FFFF,   1'b1, 32'h7FFF_FFFF));
      plan.push_back(typed_row(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000,   1'b0, 32'h0));
      plan.push_back(typed_row(OP_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF,   1'b1, 32'h0));
      plan.push_back(typed_row(OP_GET, 32'h7FFF_FFFF, 32'h0,           1'b1, 32'hFFFF_FFFF));
      plan.push_back(typed_row(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000,   1'b0, 32'h0));
      plan.push_back(typed_row(OP_GET, 32'hFFFF_FFFF, 32'h5555_AAAA,   1'b1, 32'h0));
      plan.push_back(typed_row(OP_GET, 32'h0000_0000, 32'h0,           1'b0, 32'hFFFF_FFFF));
      plan.push_back(capacity_row(5'd0));
      // zero capacity: put is dropped, every field zero
      plan.push_back(typed_row(OP_PUT, 32'h0000_0005, 32'h0000_0005,   1'b0, 32'h0));
      plan.push_back(typed_row(OP_GET, 32'h0000_0005, 32'h0,           1'b0, 32'hFFFF_FFFF));
      plan.push_back(access_row(OP_GET, 32'h8000_0000, 32'h0));
      // three entries held, limit one: each new key evicts once
      plan.push_back(capacity_row(5'd1));
      plan.push_back(access_row(OP_PUT, 32'h0000_0001, 32'h0000_0011));
      plan.push_back(access_row(OP_PUT, 32'h0000_0002, 32'h0000_0022));
      plan.push_back(access_row(OP_GET, 32'h8000_0000, 32'h0));
      plan.push_back(access_row(OP_GET, 32'h7FFF_FFFF, 32'h0));
      plan.push_back(capacity_row(5'd2));
      plan.push_back(access_row(OP_PUT, 32'h0000_0003, 32'hDEAD_BEEF));
      // above the table size acts as full size
      plan.push_back(capacity_row(5'd31));
      plan.push_back(access_row(OP_PUT, 32'h0000_0004, 32'h1234_5678));
      plan.push_back(access_row(OP_GET, 32'h0000_0004, 32'h0));
      plan.push_back(access_row(OP_PUT, 32'h8000_0000, 32'hA5A5_5A5A));
      plan.push_back(access_row(OP_GET, 32'hFFFF_FFFF, 32'h0));
      plan.push_back(capacity_row(CAP_RESET));

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR)
            write_capacity(plan[i].value[CAP_W-1:0]);
         else
            send_access(plan[i].op, plan[i].key, plan[i].value, plan[i].typed, plan[i].want);
      end

      // key pool: extremes plus random keys, so hits and evictions are common
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;
      key_pool[2] = 32'h8000_0000;
      key_pool[3] = 32'h7FFF_FFFF;
      for (int i = 4; i < KEY_POOL; i++) key_pool[i] = $urandom;

      phase_cap   = '{16, 4, 31, 1, 0, 9, 17, 2, -1};
      phase_items = '{260, 260, 260, 200, 60, 260, 260, 200, 260};

      // random phases; a new capacity is written only once drained
      for (int p = 0; p < 9; p++) begin
         cap = (phase_cap[p] < 0) ? CAP_W'($urandom_range(31)) : CAP_W'(phase_cap[p]);
         write_capacity(cap);
         eff_cap = (cap > ENTRIES) ? ENTRIES : int'(cap);
         span    = eff_cap + eff_cap / 2 + 3;
         if (span > KEY_POOL) span = KEY_POOL;
         case (p % 4)
            0: begin source_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin source_idle_pct = 60; sink_stall_pct = 0;  end
            2: begin source_idle_pct = 0;  sink_stall_pct = 60; end
            default: begin source_idle_pct = 28; sink_stall_pct = 28; end
         endcase
         for (int n = 0; n < phase_items[p]; n++) begin
            // long receiver hold-off while requests keep coming
            if (p == 0 && n == 40) hold_request = HOLD_CYCLES;
            // sender waits out every outstanding response
            if (p == 5 && n == 100) wait_drained();
            op  = ($urandom_range(99) < 55) ? OP_PUT : OP_GET;
            key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(span - 1)] : $urandom;
            send_access(op, key, $urandom, 1'b0, rsp_type'('0));
         end
      end

      source_idle_pct = 0;
      sink_stall_pct  = 0;
      wait_drained();
      repeat (2 * LATENCY) @(negedge clock);
      if (mismatch_count == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule
